[rtl/core/lsfb_pkg.sv]
// ----------------------------------------------------------------------------
// lsfb_pkg
// Shared types and constants of the linear seam feather blend.
// ----------------------------------------------------------------------------
package lsfb_pkg;

    // widest left image that the blend accepts, larger widths saturate
    localparam logic [16:0] C_MAX_WIDTH   = 17'd4096;

    localparam logic [11:0] C_OS_RESET    = 12'd0;
    localparam logic [12:0] C_LW_RESET    = 13'd4096;

    // register index, taken from byte address bit 2
    localparam logic        C_REG_OVERLAP_START = 1'b0;
    localparam logic        C_REG_LEFT_WIDTH    = 1'b1;

    // channel order inside a t_rgb
    localparam int C_BLUE  = 0;
    localparam int C_GREEN = 1;
    localparam int C_RED   = 2;
    localparam int C_CHANS = 3;

    localparam int C_NUM_W = 20;
    localparam int C_DIV_W = 13;

    typedef logic [C_CHANS-1:0][7:0] t_rgb;

    typedef struct packed {
        logic [11:0] column;
        logic [7:0]  left_blue;
        logic [7:0]  left_green;
        logic [7:0]  left_red;
        logic [7:0]  right_blue;
        logic [7:0]  right_green;
        logic [7:0]  right_red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       in_overlap;
    } t_out_item;

    typedef struct packed {
        logic [11:0] overlap_start;
        logic [12:0] left_width;
    } t_cfg;

    // side information that rides along with the numerators
    typedef struct packed {
        logic [C_DIV_W-1:0] divisor;
        logic               blend;
        logic               in_overlap;
        t_rgb               bypass;
    } t_div_meta;

    typedef struct packed {
        logic [C_CHANS-1:0][C_NUM_W-1:0] num;
        t_div_meta                        meta;
    } t_div_item;

endpackage

[rtl/core/lsfb_cfg.sv]
// ----------------------------------------------------------------------------
// lsfb_cfg
// APB-style register file holding the overlap start and left image width.
// ----------------------------------------------------------------------------
module lsfb_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lsfb_pkg::t_cfg    o_cfg
);

    logic [11:0] r_overlap_start;
    logic [12:0] r_left_width;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap_start <= lsfb_pkg::C_OS_RESET;
            r_left_width    <= lsfb_pkg::C_LW_RESET;
        end else if (wr_en) begin
            if (paddr[2] == lsfb_pkg::C_REG_OVERLAP_START) begin
                r_overlap_start <= pwdata[11:0];
            end else begin
                r_left_width <= pwdata[12:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lsfb_pkg::C_REG_LEFT_WIDTH) begin
            prdata = {19'd0, r_left_width};
        end else begin
            prdata = {20'd0, r_overlap_start};
        end
    end

    assign o_cfg.overlap_start = r_overlap_start;
    assign o_cfg.left_width    = r_left_width;

endmodule

[rtl/core/lsfb_front.sv]
// ----------------------------------------------------------------------------
// lsfb_front
// Region decode, weight products and numerator sums, three register stages.
// ----------------------------------------------------------------------------
module lsfb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsfb_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lsfb_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lsfb_pkg::t_div_item  o_item
);

    localparam int NS = 3;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    // stage 1: region decode
    logic [12:0]         lw_eff;
    logic                beyond;
    logic                left_of;
    logic                black;
    lsfb_pkg::t_rgb      in_l;
    lsfb_pkg::t_rgb      in_r;
    lsfb_pkg::t_div_meta n_meta1;
    logic [11:0]         n_k1;
    lsfb_pkg::t_rgb      r1_l;
    lsfb_pkg::t_rgb      r1_r;
    logic [11:0]         r1_k;
    lsfb_pkg::t_div_meta r1_meta;

    // stage 2: products
    logic [12:0]         wk;
    logic [20:0]         n_pl [lsfb_pkg::C_CHANS];
    logic [19:0]         n_pr [lsfb_pkg::C_CHANS];
    logic [20:0]         r2_pl [lsfb_pkg::C_CHANS];
    logic [19:0]         r2_pr [lsfb_pkg::C_CHANS];
    lsfb_pkg::t_div_meta r2_meta;

    // stage 3: sums
    logic [lsfb_pkg::C_CHANS-1:0][lsfb_pkg::C_NUM_W-1:0] r3_num;
    lsfb_pkg::t_div_meta r3_meta;

    // a stage loads when empty or when the one after it moves
    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        in_l[lsfb_pkg::C_BLUE]  = i_item.left_blue;
        in_l[lsfb_pkg::C_GREEN] = i_item.left_green;
        in_l[lsfb_pkg::C_RED]   = i_item.left_red;
        in_r[lsfb_pkg::C_BLUE]  = i_item.right_blue;
        in_r[lsfb_pkg::C_GREEN] = i_item.right_green;
        in_r[lsfb_pkg::C_RED]   = i_item.right_red;

        if ({4'd0, i_cfg.left_width} > lsfb_pkg::C_MAX_WIDTH) begin
            lw_eff = 13'(lsfb_pkg::C_MAX_WIDTH);
        end else begin
            lw_eff = i_cfg.left_width;
        end

        beyond  = {1'b0, i_item.column} >= lw_eff;
        left_of = i_item.column < i_cfg.overlap_start;
        black   = (in_r == '0);

        n_meta1.divisor    = lw_eff - {1'b0, i_cfg.overlap_start};
        n_meta1.in_overlap = !beyond && !left_of;
        n_meta1.blend      = !beyond && !left_of && !black;
        n_meta1.bypass     = beyond ? in_r : in_l;
        n_k1               = i_item.column - i_cfg.overlap_start;
    end

    always_comb begin
        wk = r1_meta.divisor - {1'b0, r1_k};
        for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
            n_pl[c] = 21'(r1_l[c]) * 21'(wk);
            n_pr[c] = 20'(r1_r[c]) * 20'(r1_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_l    <= in_l;
            r1_r    <= in_r;
            r1_k    <= n_k1;
            r1_meta <= n_meta1;
        end
        if (en[1]) begin
            r2_pl   <= n_pl;
            r2_pr   <= n_pr;
            r2_meta <= r1_meta;
        end
        if (en[2]) begin
            // sum is at most 255 * divisor, so 20 bits hold it
            for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
                r3_num[c] <= 20'(r2_pl[c] + 21'(r2_pr[c]));
            end
            r3_meta <= r2_meta;
        end
    end

    assign o_valid     = r_v[NS-1];
    assign o_item.num  = r3_num;
    assign o_item.meta = r3_meta;

endmodule

[rtl/core/lsfb_div.sv]
// ----------------------------------------------------------------------------
// lsfb_div
// Pipelined restoring divider, two quotient bits per stage, three channels,
// with the final pass-through selection.
// ----------------------------------------------------------------------------
module lsfb_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lsfb_pkg::t_div_item  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lsfb_pkg::t_out_item  o_item
);

    localparam int NS = 4;

    typedef struct packed {
        logic [lsfb_pkg::C_NUM_W-1:0] rem;
        logic [1:0]                   q;
    } t_step;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    logic [lsfb_pkg::C_NUM_W-1:0] src_rem [NS][lsfb_pkg::C_CHANS];
    logic [7:0]                   src_q   [NS][lsfb_pkg::C_CHANS];
    lsfb_pkg::t_div_meta          src_meta [NS];
    t_step                        st      [NS][lsfb_pkg::C_CHANS];

    logic [lsfb_pkg::C_NUM_W-1:0] r_rem  [NS-1][lsfb_pkg::C_CHANS];
    logic [7:0]                   r_q    [NS][lsfb_pkg::C_CHANS];
    lsfb_pkg::t_div_meta          r_meta [NS];

    // trial subtract of d shifted by sh+1, then by sh
    function automatic t_step div_step(
        input logic [lsfb_pkg::C_NUM_W-1:0] rem,
        input logic [lsfb_pkg::C_DIV_W-1:0] d,
        input logic [2:0]                   sh
    );
        logic [lsfb_pkg::C_NUM_W:0] r;
        logic [lsfb_pkg::C_NUM_W:0] t;
        t_step                      res;
        r     = {1'b0, rem};
        res.q = 2'b00;
        t     = (lsfb_pkg::C_NUM_W + 1)'(d) << (sh + 3'd1);
        if (r >= t) begin
            r        = r - t;
            res.q[1] = 1'b1;
        end
        t = (lsfb_pkg::C_NUM_W + 1)'(d) << sh;
        if (r >= t) begin
            r        = r - t;
            res.q[0] = 1'b1;
        end
        res.rem = r[lsfb_pkg::C_NUM_W-1:0];
        return res;
    endfunction

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        src_meta[0] = i_item.meta;
        for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
            src_rem[0][c] = i_item.num[c];
            src_q[0][c]   = 8'd0;
        end
        for (int s = 1; s < NS; s++) begin
            src_meta[s] = r_meta[s-1];
            for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
                src_rem[s][c] = r_rem[s-1][c];
                src_q[s][c]   = r_q[s-1][c];
            end
        end
        for (int s = 0; s < NS; s++) begin
            for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
                st[s][c] = div_step(src_rem[s][c], src_meta[s].divisor,
                                    3'(6 - 2 * s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                r_meta[s] <= src_meta[s];
                for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
                    r_q[s][c] <= {src_q[s][c][5:0], st[s][c].q};
                end
            end
        end
        for (int s = 0; s < NS - 1; s++) begin
            if (en[s]) begin
                for (int c = 0; c < lsfb_pkg::C_CHANS; c++) begin
                    r_rem[s][c] <= st[s][c].rem;
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];

    always_comb begin
        if (r_meta[NS-1].blend) begin
            o_item.out_blue  = r_q[NS-1][lsfb_pkg::C_BLUE];
            o_item.out_green = r_q[NS-1][lsfb_pkg::C_GREEN];
            o_item.out_red   = r_q[NS-1][lsfb_pkg::C_RED];
        end else begin
            o_item.out_blue  = r_meta[NS-1].bypass[lsfb_pkg::C_BLUE];
            o_item.out_green = r_meta[NS-1].bypass[lsfb_pkg::C_GREEN];
            o_item.out_red   = r_meta[NS-1].bypass[lsfb_pkg::C_RED];
        end
        o_item.in_overlap = r_meta[NS-1].in_overlap;
    end

endmodule

[rtl/core/linear_seam_feather_blend.sv]
// ----------------------------------------------------------------------------
// linear_seam_feather_blend
// Feathered linear blend of a left and a warped right pixel across the seam.
//
//   channel   direction   handshake             payload
//   pixel in  in          i_valid / o_stall     i_item (lsfb_pkg::t_in_item)
//   pixel out out         o_valid / i_stall     o_item (lsfb_pkg::t_out_item)
//   config    in          psel/penable/pwrite   paddr, pwdata, prdata
//
// one pixel per clock sustained while the output is not stalled
// each pixel passes three decode/product/sum stages and four divider stages
// synchronous reset empties every stage and restores both registers
// a stalled result holds while empty stages behind it keep taking pixels
// ----------------------------------------------------------------------------
module linear_seam_feather_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lsfb_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lsfb_pkg::t_out_item  o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    lsfb_pkg::t_cfg      cfg;
    lsfb_pkg::t_div_item mid_item;
    logic                mid_valid;
    logic                mid_stall;

    lsfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lsfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (mid_valid),
        .i_stall (mid_stall),
        .o_item  (mid_item)
    );

    lsfb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_stall (mid_stall),
        .i_item  (mid_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

[rtl/core/lsfb_checker.sv]
// ----------------------------------------------------------------------------
// lsfb_checker
// Port-level checks of the feather blend, bound to the top level.
// ----------------------------------------------------------------------------
module lsfb_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  lsfb_pkg::t_in_item   i_item,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  lsfb_pkg::t_out_item  o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic [31:0]          prdata,
    input  logic                 pready
);

    // a result waiting on a stall keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // a pixel held off at the input keeps its value
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("stalled pixel changed");

    // the input is only held off when the result itself is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // overlap start reads back what was written
    a_os_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready && !paddr[2])
        && !paddr[2] |-> prdata[11:0] == $past(pwdata[11:0]))
        else $error("overlap start readback mismatch");

endmodule

bind linear_seam_feather_blend lsfb_checker u_lsfb_checker (.*);
